/* design/rosa_pkg.sv */
package rosa_pkg;

  localparam int CrdW = 16;             // Q12.4 input coordinate
  localparam int DifW = CrdW + 1;       // difference of two coordinates
  localparam int PrdW = 2 * DifW;       // one coordinate product
  localparam int DotW = PrdW + 3;       // dot product, incl. derived corner
  localparam int NumAxes = 4;
  localparam int NumPts = 3;            // projected corners, fourth is derived
  localparam int NumStg = 5;

  typedef logic signed [CrdW-1:0] coord_t;
  typedef logic signed [DifW-1:0] dif_t;
  typedef logic signed [PrdW-1:0] prod_t;
  typedef logic signed [DotW-1:0] dot_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef struct packed {
    dif_t x;
    dif_t y;
  } vec_t;

  // One rectangle pair as it arrives
  typedef struct packed {
    pt_t a_tl;
    pt_t a_tr;
    pt_t a_bl;
    pt_t b_tl;
    pt_t b_tr;
    pt_t b_bl;
  } pair_t;

  // Edge direction plus the other rectangle's TL, TR, BL relative to the edge start
  typedef struct packed {
    vec_t               e;
    vec_t [NumPts-1:0]  p;
  } axis_in_t;

  // Per-stage advance and valid, stage 0 is the first register stage
  typedef struct packed {
    logic [NumStg-1:0] en;
    logic [NumStg-1:0] vld;
  } pipe_ctl_t;

endpackage

/* design/rosa_if.sv */
interface rosa_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  a_tl_x;
  logic signed [15:0]  a_tl_y;
  logic signed [15:0]  a_tr_x;
  logic signed [15:0]  a_tr_y;
  logic signed [15:0]  a_bl_x;
  logic signed [15:0]  a_bl_y;
  logic signed [15:0]  b_tl_x;
  logic signed [15:0]  b_tl_y;
  logic signed [15:0]  b_tr_x;
  logic signed [15:0]  b_tr_y;
  logic signed [15:0]  b_bl_x;
  logic signed [15:0]  b_bl_y;

  modport source (
    output valid, a_tl_x, a_tl_y, a_tr_x, a_tr_y, a_bl_x, a_bl_y,
           b_tl_x, b_tl_y, b_tr_x, b_tr_y, b_bl_x, b_bl_y,
    input  ready
  );
  modport sink (
    input  valid, a_tl_x, a_tl_y, a_tr_x, a_tr_y, a_bl_x, a_bl_y,
           b_tl_x, b_tl_y, b_tr_x, b_tr_y, b_bl_x, b_bl_y,
    output ready
  );
endinterface

interface rosa_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

/* design/rosa_prep.sv */
module rosa_prep
  import rosa_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  pair_t                     pair,
  output axis_in_t [NumAxes-1:0]    ax_r
);

  axis_in_t [NumAxes-1:0] ax_nxt;

  function automatic vec_t vdiff(pt_t p, pt_t s);
    vec_t r;
    r.x = dif_t'(p.x) - dif_t'(s.x);
    r.y = dif_t'(p.y) - dif_t'(s.y);
    return r;
  endfunction

  always_comb begin
    // A's top and left edges against B's corners
    ax_nxt[0].e    = vdiff(pair.a_tr, pair.a_tl);
    ax_nxt[1].e    = vdiff(pair.a_bl, pair.a_tl);
    ax_nxt[0].p[0] = vdiff(pair.b_tl, pair.a_tl);
    ax_nxt[0].p[1] = vdiff(pair.b_tr, pair.a_tl);
    ax_nxt[0].p[2] = vdiff(pair.b_bl, pair.a_tl);
    ax_nxt[1].p    = ax_nxt[0].p;
    // B's top and left edges against A's corners
    ax_nxt[2].e    = vdiff(pair.b_tr, pair.b_tl);
    ax_nxt[3].e    = vdiff(pair.b_bl, pair.b_tl);
    ax_nxt[2].p[0] = vdiff(pair.a_tl, pair.b_tl);
    ax_nxt[2].p[1] = vdiff(pair.a_tr, pair.b_tl);
    ax_nxt[2].p[2] = vdiff(pair.a_bl, pair.b_tl);
    ax_nxt[3].p    = ax_nxt[2].p;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= ax_nxt;
    end
  end

endmodule

/* design/rosa_axis.sv */
module rosa_axis
  import rosa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  pipe_ctl_t  ctl,
  input  axis_in_t   ax,
  output logic       sep
);

  // products
  prod_t              lx_r, ly_r;
  prod_t [NumPts-1:0] px_r, py_r;
  prod_t              lx_nxt, ly_nxt;
  prod_t [NumPts-1:0] px_nxt, py_nxt;
  // dot products
  dot_t               len3_r;
  dot_t [NumPts-1:0]  d3_r;
  // with derived bottom-right projection
  dot_t               len4_r;
  dot_t [NumPts:0]    d4_r;
  logic [NumPts:0]    neg;
  logic [NumPts:0]    far;

  always_comb begin
    lx_nxt = $signed(ax.e.x) * $signed(ax.e.x);
    ly_nxt = $signed(ax.e.y) * $signed(ax.e.y);
    for (int i = 0; i < NumPts; i++) begin
      px_nxt[i] = $signed(ax.p[i].x) * $signed(ax.e.x);
      py_nxt[i] = $signed(ax.p[i].y) * $signed(ax.e.y);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      lx_r <= lx_nxt;
      ly_r <= ly_nxt;
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
    if (ctl.en[2]) begin
      len3_r <= dot_t'($signed(lx_r)) + dot_t'($signed(ly_r));
      for (int i = 0; i < NumPts; i++) begin
        d3_r[i] <= dot_t'($signed(px_r[i])) + dot_t'($signed(py_r[i]));
      end
    end
    if (ctl.en[3]) begin
      len4_r          <= len3_r;
      d4_r[NumPts-1:0] <= d3_r;
      // projection is linear: BR = TR + BL - TL
      d4_r[NumPts]    <= $signed(d3_r[1]) + $signed(d3_r[2]) - $signed(d3_r[0]);
    end
  end

  always_comb begin
    for (int i = 0; i <= NumPts; i++) begin
      neg[i] = d4_r[i][DotW-1];
      far[i] = $signed(d4_r[i]) > $signed(len4_r);
    end
    sep = (&neg) | (&far);
  end

`ifndef ASSERT_OFF
  a_zero_edge_never_sep: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.vld[3] && (len4_r == '0) |-> !sep)
    else $error("zero-length edge reported as separating");

  a_len_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.vld[3] |-> !len4_r[DotW-1])
    else $error("squared edge length negative");
`endif

endmodule

/* design/rect_overlap_separating_axis.sv */
// Rectangle overlap by separating-axis test, one rectangle pair per request.
// Stages from input accept to result valid: prep, multiply, dot, corner derive,
// decision. Throughput: one request per cycle while the output is not stalled;
// a downstream stall holds the full stages while bubbles collapse, and input
// stalls once all five stages hold a request.
// Reset clears the stage valid bits only; the datapath is not reset.
module rect_overlap_separating_axis
  import rosa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  rosa_in_if.sink           in_chan,
  rosa_out_if.source        out_chan
);

  pair_t                   pair;
  axis_in_t [NumAxes-1:0]  ax_r;
  logic [NumAxes-1:0]      sep;
  logic [NumStg-1:0]       vld_r, vld_nxt;
  logic [NumStg-1:0]       adv;
  logic [NumStg-1:0]       en;
  pipe_ctl_t               ctl;
  logic                    overlap_r;

  // Gather the request fields into one pair struct.
  always_comb begin
    pair.a_tl.x = in_chan.a_tl_x;
    pair.a_tl.y = in_chan.a_tl_y;
    pair.a_tr.x = in_chan.a_tr_x;
    pair.a_tr.y = in_chan.a_tr_y;
    pair.a_bl.x = in_chan.a_bl_x;
    pair.a_bl.y = in_chan.a_bl_y;
    pair.b_tl.x = in_chan.b_tl_x;
    pair.b_tl.y = in_chan.b_tl_y;
    pair.b_tr.x = in_chan.b_tr_x;
    pair.b_tr.y = in_chan.b_tr_y;
    pair.b_bl.x = in_chan.b_bl_x;
    pair.b_bl.y = in_chan.b_bl_y;
  end

  // Pipeline control: a stage advances when it is empty or the next one
  // advances, so bubbles collapse and a stall drops nothing.
  always_comb begin
    adv[NumStg-1] = !vld_r[NumStg-1] || out_chan.ready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    en[0]      = adv[0] && in_chan.valid;
    vld_nxt[0] = adv[0] ? in_chan.valid : vld_r[0];
    for (int k = 1; k < NumStg; k++) begin
      en[k]      = adv[k] && vld_r[k-1];
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
    ctl.en  = en;
    ctl.vld = vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 0: edge directions and corner offsets.
  rosa_prep u_prep (
    .clk  (clk),
    .en   (en[0]),
    .pair (pair),
    .ax_r (ax_r)
  );

  // Stages 1..3: one lane per axis (A top, A left, B top, B left).
  for (genvar g = 0; g < NumAxes; g++) begin : g_axis
    rosa_axis u_axis (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .ax    (ax_r[g]),
      .sep   (sep[g])
    );
  end

  // Stage 4: result register, overlap unless some axis separates.
  always_ff @(posedge clk) begin
    if (en[NumStg-1]) begin
      overlap_r <= ~|sep;
    end
  end

  assign in_chan.ready    = adv[0];
  assign out_chan.valid   = vld_r[NumStg-1];
  assign out_chan.overlap = overlap_r;

`ifndef ASSERT_OFF
  a_empty_out_takes_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_chan.valid |-> in_chan.ready)
    else $error("input stalled with empty result stage");

  a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> vld_r[0])
    else $error("accepted request not captured");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] && !adv[2] |=> vld_r[2])
    else $error("stalled stage lost its request");
`endif

endmodule
